// ===== src/tpef_pkg.sv =====
// Shared types, constants and saturating Q16.16 arithmetic for the two-phase flux pipeline.
package tpef_pkg;

  localparam int DIV_STEPS  = 32;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int SQRT_STEPS = 24;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;

  localparam logic signed [31:0] FX_ONE  = 32'sd65536;
  localparam logic signed [31:0] FX_HALF = 32'sd32768;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REG_HEAT_RATIO     = 2'd0,
    REG_STIFFNESS      = 2'd1,
    REG_DENSITY_FLOOR  = 2'd2,
    REG_PRESSURE_FLOOR = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_LOW_DENSITY  = 2'd1,
    ST_LOW_PRESSURE = 2'd2
  } status_e;

  // Magnitude of a signed word; the most negative value gives 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    mag32 = a[31] ? (~a + 32'd1) : a;
  endfunction

  // Applies a sign to a magnitude and saturates to the signed 32-bit range.
  function automatic logic signed [31:0] sat_signed(input logic [47:0] r, input logic neg);
    logic signed [31:0] res;
    if (neg) begin
      if (r > 48'h0000_8000_0000) res = S32_MIN;
      else res = -$signed(r[31:0]);
    end else begin
      if (r > 48'h0000_7FFF_FFFF) res = S32_MAX;
      else res = $signed(r[31:0]);
    end
    sat_signed = res;
  endfunction

  function automatic logic signed [31:0] fadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sh0_7FFF_FFFF) fadd = S32_MAX;
    else if (s < -33'sh0_8000_0000) fadd = S32_MIN;
    else fadd = s[31:0];
  endfunction

  function automatic logic signed [31:0] fsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    if (s > 33'sh0_7FFF_FFFF) fsub = S32_MAX;
    else if (s < -33'sh0_8000_0000) fsub = S32_MIN;
    else fsub = s[31:0];
  endfunction

  function automatic logic signed [31:0] fabsx(input logic signed [31:0] a);
    if (a == S32_MIN) fabsx = S32_MAX;
    else if (a[31]) fabsx = -a;
    else fabsx = a;
  endfunction

  // Product rounded to nearest, ties away from zero.
  function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [63:0] pr;
    pr = {32'd0, mag32(a)} * {32'd0, mag32(b)};
    pr = pr + 64'd32768;
    fmul = sat_signed(pr[63:16], a[31] ^ b[31]);
  endfunction

endpackage

// ===== src/tpef_div.sv =====
// Pipelined restoring divider for Q16.16 quotients, one quotient bit per stage.
module tpef_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  output logic signed [31:0] quotient_o
);

  localparam int Steps = tpef_pkg::DIV_STEPS;

  typedef enum logic [1:0] {RES_NORMAL, RES_MAX, RES_MIN, RES_ZERO} res_e;

  logic [48:0] rem_q [0:Steps];
  logic [31:0] den_q [0:Steps];
  logic [31:0] quo_q [0:Steps];
  logic        neg_q [0:Steps];
  res_e        res_q [0:Steps];

  logic [31:0] ma, mb;
  logic [48:0] sum;
  logic        ovf;
  res_e        res_d;

  always_comb begin
    ma  = tpef_pkg::mag32(dividend_i);
    mb  = tpef_pkg::mag32(divisor_i);
    sum = {1'b0, ma, 16'd0} + {18'd0, mb[31:1]};
    ovf = {15'd0, sum} >= {mb, 32'd0};
    if (divisor_i == 32'sd0) begin
      if (dividend_i > 32'sd0) res_d = RES_MAX;
      else if (dividend_i < 32'sd0) res_d = RES_MIN;
      else res_d = RES_ZERO;
    end else if (ovf) begin
      res_d = (dividend_i[31] ^ divisor_i[31]) ? RES_MIN : RES_MAX;
    end else begin
      res_d = RES_NORMAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= sum;
      den_q[0] <= mb;
      quo_q[0] <= '0;
      neg_q[0] <= dividend_i[31] ^ divisor_i[31];
      res_q[0] <= res_d;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [63:0] trial;
    logic        ge;
    always_comb begin
      trial = {32'd0, den_q[k]} << (Steps - 1 - k);
      ge    = {15'd0, rem_q[k]} >= trial;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? (rem_q[k] - trial[48:0]) : rem_q[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= quo_q[k] | ({31'd0, ge} << (Steps - 1 - k));
        neg_q[k+1] <= neg_q[k];
        res_q[k+1] <= res_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (res_q[Steps])
        RES_MAX:  quotient_o <= tpef_pkg::S32_MAX;
        RES_MIN:  quotient_o <= tpef_pkg::S32_MIN;
        RES_ZERO: quotient_o <= '0;
        default:  quotient_o <= tpef_pkg::sat_signed({16'd0, quo_q[Steps]}, neg_q[Steps]);
      endcase
    end
  end

endmodule

// ===== src/tpef_sqrt.sv =====
// Pipelined truncating square root of a Q16.16 value, two radicand bits per stage.
module tpef_sqrt (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] arg_i,
  output logic [23:0]        root_o
);

  localparam int Steps = tpef_pkg::SQRT_STEPS;

  logic [47:0] rad_q  [0:Steps];
  logic [25:0] rem_q  [0:Steps];
  logic [23:0] root_q [0:Steps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= (arg_i > 32'sd0) ? {1'b0, arg_i[30:0], 16'd0} : '0;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [27:0] remsh;
    logic [25:0] trial;
    logic        ge;
    always_comb begin
      remsh = {rem_q[k], rad_q[k][47 - 2*k -: 2]};
      trial = {root_q[k], 2'b01};
      ge    = remsh >= {2'b00, trial};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1]  <= rad_q[k];
        rem_q[k+1]  <= ge ? 26'(remsh - {2'b00, trial}) : remsh[25:0];
        root_q[k+1] <= {root_q[k][22:0], ge};
      end
    end
  end

  assign root_o = root_q[Steps];

endmodule

// ===== src/two_phase_euler_flux.sv =====
// Top level of the two-phase stiffened-gas normal flux pipeline.
// Each item is one cell state and face normal; the block returns the mass, momentum and
// energy fluxes along the normal in signed Q16.16, the largest signal speed in unsigned
// Q15.16 and a status code. One item can enter in every clock cycle and one result leaves
// per cycle while the output is not stalled. It is built from two chained 34-stage dividers
// (density, then its reciprocal), six multiply stages, the 25-stage square root and the
// output register. The pipeline advances as a whole; it freezes only while a result in the
// output register is stalled, so an item is taken whenever that register is empty or being
// emptied. Configuration registers are read live and must only be written while the block
// holds no items in flight. A state with density or pressure below its floor gives zero
// fluxes and speed, with the density check taking priority.
module two_phase_euler_flux (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] mass_i,
  input  logic signed [31:0] momentum_x_i,
  input  logic signed [31:0] momentum_y_i,
  input  logic signed [31:0] energy_i,
  input  logic signed [31:0] volume_fraction_i,
  input  logic signed [31:0] solid_vel_x_i,
  input  logic signed [31:0] solid_vel_y_i,
  input  logic signed [31:0] normal_x_i,
  input  logic signed [31:0] normal_y_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] flux_mass_o,
  output logic signed [31:0] flux_mom_x_o,
  output logic signed [31:0] flux_mom_y_o,
  output logic signed [31:0] flux_energy_o,
  output logic [30:0]        max_speed_o,
  output logic [1:0]         status_o
);

  localparam int DivLat  = tpef_pkg::DIV_LAT;
  localparam int SqrtLat = tpef_pkg::SQRT_LAT;

  // Fields carried alongside the first divider.
  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] alpha;
    logic signed [31:0] usx;
    logic signed [31:0] usy;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
  } side1_t;

  // Fields carried alongside the reciprocal divider.
  typedef struct packed {
    logic signed [31:0] rho;
    logic signed [31:0] e;
    side1_t             s1;
  } side2_t;

  // Partial results carried alongside the square root.
  typedef struct packed {
    logic signed [31:0] f0;
    logic signed [31:0] f1a;
    logic signed [31:0] f1b;
    logic signed [31:0] f2a;
    logic signed [31:0] f2b;
    logic signed [31:0] f3;
    logic signed [31:0] absun;
    logic signed [31:0] ss;
    logic [1:0]         status;
  } side3_t;

  // Configuration registers.
  logic [19:0]        heat_ratio_q;
  logic [30:0]        stiffness_q;
  logic [30:0]        density_floor_q;
  logic signed [31:0] pressure_floor_q;

  logic signed [31:0] g, pi;

  assign cfg_ready_o = 1'b1;
  assign g  = {12'd0, heat_ratio_q};
  assign pi = {1'b0, stiffness_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_ratio_q     <= 20'd91750;
      stiffness_q      <= '0;
      density_floor_q  <= 31'd1;
      pressure_floor_q <= 32'sd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tpef_pkg::REG_HEAT_RATIO:     heat_ratio_q     <= cfg_data_i[19:0];
        tpef_pkg::REG_STIFFNESS:      stiffness_q      <= cfg_data_i[30:0];
        tpef_pkg::REG_DENSITY_FLOOR:  density_floor_q  <= cfg_data_i[30:0];
        tpef_pkg::REG_PRESSURE_FLOOR: pressure_floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless a finished result is held by the consumer.
  logic adv;
  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;

  // Density and energy, each divided by the volume fraction.
  logic signed [31:0] rho_w, e_w, irho_w;

  tpef_div u_div_rho (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (mass_i),
    .divisor_i  (volume_fraction_i),
    .quotient_o (rho_w)
  );

  tpef_div u_div_energy (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (energy_i),
    .divisor_i  (volume_fraction_i),
    .quotient_o (e_w)
  );

  side1_t d1_q [0:DivLat-1];
  logic   v1_q [0:DivLat-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q[0] <= '{mx: momentum_x_i, my: momentum_y_i, alpha: volume_fraction_i,
                   usx: solid_vel_x_i, usy: solid_vel_y_i, nx: normal_x_i, ny: normal_y_i};
      for (int i = 1; i < DivLat; i++) d1_q[i] <= d1_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivLat; i++) v1_q[i] <= 1'b0;
    end else if (adv) begin
      v1_q[0] <= valid_i;
      for (int i = 1; i < DivLat; i++) v1_q[i] <= v1_q[i-1];
    end
  end

  // Reciprocal density.
  tpef_div u_div_irho (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (tpef_pkg::FX_ONE),
    .divisor_i  (rho_w),
    .quotient_o (irho_w)
  );

  side2_t d2_q [0:DivLat-1];
  logic   v2_q [0:DivLat-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_q[0] <= '{rho: rho_w, e: e_w, s1: d1_q[DivLat-1]};
      for (int i = 1; i < DivLat; i++) d2_q[i] <= d2_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivLat; i++) v2_q[i] <= 1'b0;
    end else if (adv) begin
      v2_q[0] <= v1_q[DivLat-1];
      for (int i = 1; i < DivLat; i++) v2_q[i] <= v2_q[i-1];
    end
  end

  side2_t s2;
  assign s2 = d2_q[DivLat-1];

  // Valid bits of the six arithmetic stages.
  logic [5:0] vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= '0;
    end else if (adv) begin
      vc_q <= {vc_q[4:0], v2_q[DivLat-1]};
    end
  end

  // Stage 1: velocities, half density, gamma over density, solid velocity products.
  logic signed [31:0] c1_u_q, c1_v_q, c1_hr_q, c1_gi_q, c1_sm1_q, c1_sm2_q;
  logic signed [31:0] c1_rho_q, c1_e_q, c1_alpha_q, c1_nx_q, c1_ny_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_u_q     <= tpef_pkg::fmul(irho_w, s2.s1.mx);
      c1_v_q     <= tpef_pkg::fmul(irho_w, s2.s1.my);
      c1_hr_q    <= tpef_pkg::fmul(tpef_pkg::FX_HALF, s2.rho);
      c1_gi_q    <= tpef_pkg::fmul(g, irho_w);
      c1_sm1_q   <= tpef_pkg::fmul(s2.s1.usx, s2.s1.nx);
      c1_sm2_q   <= tpef_pkg::fmul(s2.s1.usy, s2.s1.ny);
      c1_rho_q   <= s2.rho;
      c1_e_q     <= s2.e;
      c1_alpha_q <= s2.s1.alpha;
      c1_nx_q    <= s2.s1.nx;
      c1_ny_q    <= s2.s1.ny;
    end
  end

  // Stage 2: squares, normal projections and the solid normal speed.
  logic signed [31:0] c2_uu_q, c2_vv_q, c2_nu_q, c2_nv_q, c2_nxa_q, c2_nya_q, c2_ss_q;
  logic signed [31:0] c2_hr_q, c2_u_q, c2_v_q, c2_rho_q, c2_e_q, c2_alpha_q, c2_gi_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_uu_q    <= tpef_pkg::fmul(c1_u_q, c1_u_q);
      c2_vv_q    <= tpef_pkg::fmul(c1_v_q, c1_v_q);
      c2_nu_q    <= tpef_pkg::fmul(c1_nx_q, c1_u_q);
      c2_nv_q    <= tpef_pkg::fmul(c1_ny_q, c1_v_q);
      c2_nxa_q   <= tpef_pkg::fmul(c1_nx_q, c1_alpha_q);
      c2_nya_q   <= tpef_pkg::fmul(c1_ny_q, c1_alpha_q);
      c2_ss_q    <= tpef_pkg::fabsx(tpef_pkg::fadd(c1_sm1_q, c1_sm2_q));
      c2_hr_q    <= c1_hr_q;
      c2_u_q     <= c1_u_q;
      c2_v_q     <= c1_v_q;
      c2_rho_q   <= c1_rho_q;
      c2_e_q     <= c1_e_q;
      c2_alpha_q <= c1_alpha_q;
      c2_gi_q    <= c1_gi_q;
    end
  end

  // Stage 3: kinetic energy and normal velocity.
  logic signed [31:0] c3_ke_q, c3_un_q;
  logic signed [31:0] c3_u_q, c3_v_q, c3_rho_q, c3_e_q, c3_alpha_q, c3_gi_q;
  logic signed [31:0] c3_nxa_q, c3_nya_q, c3_ss_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c3_ke_q    <= tpef_pkg::fmul(c2_hr_q, tpef_pkg::fadd(c2_uu_q, c2_vv_q));
      c3_un_q    <= tpef_pkg::fadd(c2_nu_q, c2_nv_q);
      c3_u_q     <= c2_u_q;
      c3_v_q     <= c2_v_q;
      c3_rho_q   <= c2_rho_q;
      c3_e_q     <= c2_e_q;
      c3_alpha_q <= c2_alpha_q;
      c3_gi_q    <= c2_gi_q;
      c3_nxa_q   <= c2_nxa_q;
      c3_nya_q   <= c2_nya_q;
      c3_ss_q    <= c2_ss_q;
    end
  end

  // Stage 4: pressure before the stiffness term, gamma times stiffness, alpha times normal velocity.
  logic signed [31:0] c4_t_q, c4_aun_q, c4_gpi_q;
  logic signed [31:0] c4_u_q, c4_v_q, c4_rho_q, c4_e_q, c4_gi_q;
  logic signed [31:0] c4_nxa_q, c4_nya_q, c4_ss_q, c4_un_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c4_t_q   <= tpef_pkg::fmul(tpef_pkg::fsub(g, tpef_pkg::FX_ONE),
                                 tpef_pkg::fsub(c3_e_q, c3_ke_q));
      c4_aun_q <= tpef_pkg::fmul(c3_alpha_q, c3_un_q);
      c4_gpi_q <= tpef_pkg::fmul(g, pi);
      c4_u_q   <= c3_u_q;
      c4_v_q   <= c3_v_q;
      c4_rho_q <= c3_rho_q;
      c4_e_q   <= c3_e_q;
      c4_gi_q  <= c3_gi_q;
      c4_nxa_q <= c3_nxa_q;
      c4_nya_q <= c3_nya_q;
      c4_ss_q  <= c3_ss_q;
      c4_un_q  <= c3_un_q;
    end
  end

  // Stage 5: pressure, mass flux and the density check.
  logic signed [31:0] c5_p_q, c5_rhoun_q;
  logic               c5_low_rho_q;
  logic signed [31:0] c5_u_q, c5_v_q, c5_e_q, c5_gi_q, c5_nxa_q, c5_nya_q;
  logic signed [31:0] c5_ss_q, c5_un_q, c5_aun_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c5_p_q       <= tpef_pkg::fsub(c4_t_q, c4_gpi_q);
      c5_rhoun_q   <= tpef_pkg::fmul(c4_rho_q, c4_aun_q);
      c5_low_rho_q <= c4_rho_q < $signed({1'b0, density_floor_q});
      c5_u_q       <= c4_u_q;
      c5_v_q       <= c4_v_q;
      c5_e_q       <= c4_e_q;
      c5_gi_q      <= c4_gi_q;
      c5_nxa_q     <= c4_nxa_q;
      c5_nya_q     <= c4_nya_q;
      c5_ss_q      <= c4_ss_q;
      c5_un_q      <= c4_un_q;
      c5_aun_q     <= c4_aun_q;
    end
  end

  // Stage 6: flux products, sound speed argument and the status code.
  logic signed [31:0] c6_sarg_q;
  side3_t             c6_q;
  logic [1:0]         status_d;

  always_comb begin
    if (c5_low_rho_q) status_d = tpef_pkg::ST_LOW_DENSITY;
    else if (c5_p_q < pressure_floor_q) status_d = tpef_pkg::ST_LOW_PRESSURE;
    else status_d = tpef_pkg::ST_OK;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c6_sarg_q     <= tpef_pkg::fmul(c5_gi_q, tpef_pkg::fadd(c5_p_q, pi));
      c6_q.f0       <= c5_rhoun_q;
      c6_q.f1a      <= tpef_pkg::fmul(c5_rhoun_q, c5_u_q);
      c6_q.f1b      <= tpef_pkg::fmul(c5_nxa_q, c5_p_q);
      c6_q.f2a      <= tpef_pkg::fmul(c5_rhoun_q, c5_v_q);
      c6_q.f2b      <= tpef_pkg::fmul(c5_nya_q, c5_p_q);
      c6_q.f3       <= tpef_pkg::fmul(tpef_pkg::fadd(c5_e_q, c5_p_q), c5_aun_q);
      c6_q.absun    <= tpef_pkg::fabsx(c5_un_q);
      c6_q.ss       <= c5_ss_q;
      c6_q.status   <= status_d;
    end
  end

  // Sound speed.
  logic [23:0] root_w;

  tpef_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .arg_i  (c6_sarg_q),
    .root_o (root_w)
  );

  side3_t d3_q [0:SqrtLat-1];
  logic   v3_q [0:SqrtLat-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d3_q[0] <= c6_q;
      for (int i = 1; i < SqrtLat; i++) d3_q[i] <= d3_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SqrtLat; i++) v3_q[i] <= 1'b0;
    end else if (adv) begin
      v3_q[0] <= vc_q[5];
      for (int i = 1; i < SqrtLat; i++) v3_q[i] <= v3_q[i-1];
    end
  end

  // Final sums, the larger signal speed and the inadmissible-state zeroing.
  side3_t             s3;
  logic signed [31:0] sg, smax;
  logic               bad;

  assign s3   = d3_q[SqrtLat-1];
  assign sg   = tpef_pkg::fadd(s3.absun, {8'd0, root_w});
  assign smax = (s3.ss > sg) ? s3.ss : sg;
  assign bad  = s3.status != tpef_pkg::ST_OK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= v3_q[SqrtLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flux_mass_o   <= bad ? '0 : s3.f0;
      flux_mom_x_o  <= bad ? '0 : tpef_pkg::fadd(s3.f1a, s3.f1b);
      flux_mom_y_o  <= bad ? '0 : tpef_pkg::fadd(s3.f2a, s3.f2b);
      flux_energy_o <= bad ? '0 : s3.f3;
      max_speed_o   <= bad ? '0 : smax[30:0];
      status_o      <= s3.status;
    end
  end

endmodule
